@@ hw/rtl/srx_pkg.sv @@
// Shared types, constants and the CRC-16/MODBUS byte update for the sync
// frame receiver. No dependencies.
`timescale 1ns / 1ps

package srx_pkg;

	localparam logic [7:0]  SYNC0       = 8'h5A;
	localparam logic [7:0]  SYNC1       = 8'hA5;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'hA001;

	localparam logic [7:0]  CMD_ACK     = 8'h80;
	localparam logic [7:0]  CMD_COLOR   = 8'h81;
	localparam logic [7:0]  CMD_CIRCLE  = 8'h82;
	localparam logic [7:0]  CMD_DISK    = 8'h83;
	localparam logic [7:0]  CMD_QR      = 8'h84;

	localparam logic [7:0]  ACK_LEN     = 8'd2;
	localparam logic [7:0]  DISK_LEN    = 8'd7;
	localparam logic [7:0]  TARGET_MAX  = 8'd8;
	localparam logic [7:0]  QR_LEN      = 8'd16;

	localparam logic [2:0]  MODE_COLOR  = 3'd1;
	localparam logic [2:0]  MODE_CIRCLE = 3'd2;
	localparam logic [2:0]  MODE_DISK   = 3'd3;
	localparam logic [2:0]  MODE_QR     = 3'd5;

	localparam logic [1:0]  REG_SESSION = 2'd0;
	localparam logic [1:0]  REG_ACTIVE  = 2'd1;
	localparam logic [1:0]  REG_MODE    = 2'd2;

	typedef enum logic [2:0] {
		FT_ACK     = 3'd0,
		FT_TARGETS = 3'd1,
		FT_DISK    = 3'd2,
		FT_QR      = 3'd3,
		FT_OTHER   = 3'd4
	} frame_type_t;

	typedef enum logic [2:0] {
		PH_HUNT0 = 3'd0,
		PH_HUNT1 = 3'd1,
		PH_CMD   = 3'd2,
		PH_SESS  = 3'd3,
		PH_LEN   = 3'd4,
		PH_PAY   = 3'd5,
		PH_CRCL  = 3'd6,
		PH_CRCH  = 3'd7
	} phase_t;

	typedef struct packed {
		logic [7:0] session_id;
		logic       detection_active;
		logic [2:0] detection_mode;
	} cfg_t;

	typedef struct packed {
		logic       accepted;
		logic [6:0] frame_length;
		logic [2:0] frame_type;
		logic [7:0] frame_command;
		logic [6:0] payload_index;
		logic [7:0] payload_byte;
		logic       item_kind;
		logic       last;
	} result_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic frame_type_t type_of(input logic [7:0] cmd);
		frame_type_t t;
		priority if (cmd == CMD_ACK) t = FT_ACK;
		else if (cmd == CMD_COLOR || cmd == CMD_CIRCLE) t = FT_TARGETS;
		else if (cmd == CMD_DISK) t = FT_DISK;
		else if (cmd == CMD_QR) t = FT_QR;
		else t = FT_OTHER;
		return t;
	endfunction

endpackage

@@ hw/rtl/srx_cfg_regs.sv @@
// Configuration registers of the sync frame receiver: session, detection
// active flag and detection mode. Depends on srx_pkg.
`timescale 1ns / 1ps

module srx_cfg_regs import srx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SESSION: cfg_q.session_id       <= cfg_data;
				REG_ACTIVE:  cfg_q.detection_active <= cfg_data[0];
				REG_MODE:    cfg_q.detection_mode   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hw/rtl/srx_parser.sv @@
// Frame parser: sync hunt, header capture, CRC-16 accumulation and the
// verdict for one received byte per step. Depends on srx_pkg.
`timescale 1ns / 1ps

module srx_parser import srx_pkg::*; #(
	parameter int FRAME_BUFFER_BYTES = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	input  logic       abort_frame,
	input  cfg_t       cfg,
	output logic       res_valid,
	output result_t    res
);

	localparam int CNT_W = (FRAME_BUFFER_BYTES - 6 > 2) ? $clog2(FRAME_BUFFER_BYTES - 6) : 1;
	localparam logic [9:0] BUF_BYTES = 10'(FRAME_BUFFER_BYTES);

	phase_t           phase_q, phase_d;
	logic [7:0]       cmd_q, cmd_d;
	logic [7:0]       sess_q, sess_d;
	logic [7:0]       len_q, len_d;
	logic [15:0]      crc_q, crc_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [7:0]       first_q, first_d;
	logic [7:0]       crcl_q, crcl_d;

	logic [CNT_W-1:0] cnt_inc;
	logic             oversize;
	phase_t           replay_ph;
	logic             kind_ok;
	logic             mode_targets;
	logic [7:0]       target_len;

	assign cnt_inc  = cnt_q + CNT_W'(1);
	assign oversize = (10'(rx_byte) + 10'd7) > BUF_BYTES;

	// phase left after replaying 0xA5, command and session from a cold hunt
	always_comb begin
		replay_ph = (cmd_q == SYNC0) ? PH_HUNT1 : PH_HUNT0;
		if (replay_ph == PH_HUNT1) begin
			priority if (sess_q == SYNC1) replay_ph = PH_CMD;
			else if (sess_q == SYNC0) replay_ph = PH_HUNT1;
			else replay_ph = PH_HUNT0;
		end else begin
			replay_ph = (sess_q == SYNC0) ? PH_HUNT1 : PH_HUNT0;
		end
	end

	assign mode_targets = (cmd_q == CMD_COLOR && cfg.detection_mode == MODE_COLOR) ||
		(cmd_q == CMD_CIRCLE && cfg.detection_mode == MODE_CIRCLE);
	assign target_len = {first_q[4:0], 3'b000} + 8'd1;

	always_comb begin
		priority if (cmd_q == CMD_ACK) kind_ok = (len_q == ACK_LEN);
		else if (!cfg.detection_active) kind_ok = 1'b0;
		else if (mode_targets) kind_ok = (len_q != 8'd0) && (first_q <= TARGET_MAX) &&
			(len_q == target_len);
		else if (cmd_q == CMD_DISK && cfg.detection_mode == MODE_DISK)
			kind_ok = (len_q == DISK_LEN);
		else if (cmd_q == CMD_QR && cfg.detection_mode == MODE_QR)
			kind_ok = (len_q == QR_LEN);
		else kind_ok = 1'b0;
	end

	always_comb begin
		phase_d = phase_q;
		cmd_d   = cmd_q;
		sess_d  = sess_q;
		len_d   = len_q;
		crc_d   = crc_q;
		cnt_d   = cnt_q;
		first_d = first_q;
		crcl_d  = crcl_q;
		res_valid = 1'b0;
		res.item_kind     = 1'b0;
		res.payload_byte  = 8'h00;
		res.payload_index = 7'd0;
		res.frame_command = cmd_q;
		res.frame_type    = type_of(cmd_q);
		res.frame_length  = len_q[6:0];
		res.accepted      = 1'b0;
		res.last          = 1'b0;
		if (abort_frame) begin
			phase_d = PH_HUNT0;
			crc_d   = CRC_INIT;
			cnt_d   = '0;
		end else begin
			unique case (phase_q)
				PH_HUNT0: begin
					if (rx_byte == SYNC0) phase_d = PH_HUNT1;
				end
				PH_HUNT1: begin
					priority if (rx_byte == SYNC1) begin
						phase_d = PH_CMD;
						crc_d   = CRC_INIT;
					end else if (rx_byte != SYNC0) begin
						phase_d = PH_HUNT0;
					end
				end
				PH_CMD: begin
					cmd_d   = rx_byte;
					crc_d   = crc16_byte(crc_q, rx_byte);
					phase_d = PH_SESS;
				end
				PH_SESS: begin
					sess_d  = rx_byte;
					crc_d   = crc16_byte(crc_q, rx_byte);
					phase_d = PH_LEN;
				end
				PH_LEN: begin
					len_d = rx_byte;
					if (oversize) begin
						// drop the leading sync byte, rescan held bytes
						unique case (replay_ph)
							PH_HUNT1: begin
								priority if (rx_byte == SYNC1) begin
									phase_d = PH_CMD;
									crc_d   = CRC_INIT;
								end else if (rx_byte == SYNC0) begin
									phase_d = PH_HUNT1;
								end else begin
									phase_d = PH_HUNT0;
								end
							end
							PH_CMD: begin
								cmd_d   = rx_byte;
								crc_d   = crc16_byte(CRC_INIT, rx_byte);
								phase_d = PH_SESS;
							end
							default: phase_d = (rx_byte == SYNC0) ? PH_HUNT1 : PH_HUNT0;
						endcase
					end else begin
						crc_d   = crc16_byte(crc_q, rx_byte);
						cnt_d   = '0;
						first_d = 8'h00;
						phase_d = (rx_byte == 8'h00) ? PH_CRCL : PH_PAY;
					end
				end
				PH_PAY: begin
					if (cnt_q == '0) first_d = rx_byte;
					crc_d = crc16_byte(crc_q, rx_byte);
					cnt_d = cnt_inc;
					if (8'(cnt_inc) >= len_q) phase_d = PH_CRCL;
					res_valid         = 1'b1;
					res.payload_byte  = rx_byte;
					res.payload_index = 7'(cnt_q);
				end
				PH_CRCL: begin
					crcl_d  = rx_byte;
					phase_d = PH_CRCH;
				end
				PH_CRCH: begin
					phase_d = PH_HUNT0;
					crc_d   = CRC_INIT;
					cnt_d   = '0;
					res_valid     = 1'b1;
					res.item_kind = 1'b1;
					res.last      = 1'b1;
					res.accepted  = ({rx_byte, crcl_q} == crc_q) &&
						(sess_q == cfg.session_id) && kind_ok;
				end
				default: phase_d = PH_HUNT0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT0;
			cmd_q   <= '0;
			sess_q  <= '0;
			len_q   <= '0;
			crc_q   <= CRC_INIT;
			cnt_q   <= '0;
			first_q <= '0;
			crcl_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			cmd_q   <= cmd_d;
			sess_q  <= sess_d;
			len_q   <= len_d;
			crc_q   <= crc_d;
			cnt_q   <= cnt_d;
			first_q <= first_d;
			crcl_q  <= crcl_d;
		end
	end

endmodule

@@ hw/rtl/sync_crc16_frame_receiver.sv @@
// Top level of the sync frame receiver: input register, parser and result
// register. Depends on srx_pkg, srx_cfg_regs and srx_parser.
`timescale 1ns / 1ps

// Receives one serial byte per item and takes a new item every cycle while the
// result side keeps up. Each byte is held in an input register, then the
// parser updates its phase and the CRC-16/MODBUS remainder for the whole byte
// combinationally and loads the result register: a byte shows up as a result
// only after both registers. Payload bytes come out as they arrive (tuser 0)
// and are tentative; after the two CRC bytes a verdict item (tuser 1, tlast 1)
// says whether the frame passed CRC, session and kind checks, and the
// consumer drops the payload of a frame that did not. Sync bytes, header and
// CRC bytes give no result. A stalled result side holds one finished result
// and one waiting input byte before tready falls.
module sync_crc16_frame_receiver import srx_pkg::*; #(
	parameter int FRAME_BUFFER_BYTES = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // rx_byte
	input  logic [0:0]  s_axis_tuser,  // abort_frame
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // payload_byte, payload_index, frame_command,
	                                   // frame_type, frame_length, accepted, zero fill
	output logic [0:0]  m_axis_tuser,  // item_kind
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	cfg_t       cfg;
	logic       in_valid_s1;
	logic [7:0] rx_byte_s1;
	logic       abort_s1;
	logic       out_free;
	logic       step;
	logic       res_valid;
	result_t    res;
	logic       out_valid_q;
	result_t    out_q;

	srx_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign out_free      = !out_valid_q || m_axis_tready;
	assign step          = in_valid_s1 && out_free;
	assign s_axis_tready = !in_valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			rx_byte_s1 <= s_axis_tdata;
			abort_s1   <= s_axis_tuser[0];
		end
	end

	srx_parser #(
		.FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.rx_byte     (rx_byte_s1),
		.abort_frame (abort_s1),
		.cfg         (cfg),
		.res_valid   (res_valid),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) out_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b000000, out_q.accepted, out_q.frame_length, out_q.frame_type,
		out_q.frame_command, out_q.payload_index, out_q.payload_byte};
	assign m_axis_tuser  = out_q.item_kind;
	assign m_axis_tlast  = out_q.last;

endmodule
